// ----- hdl/pixel_format_converter_quant_core_defines.svh -----
// assertion macros shared by the converter core
`ifndef PIXEL_FORMAT_CONVERTER_QUANT_CORE_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_QUANT_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PFCQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PFCQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pfcq_pkg.sv -----
`default_nettype none

package pfcq_pkg;

  // quantization table geometry
  localparam int TABLE_BANK_DEPTH = 256;
  localparam int BANK_AW          = $clog2(TABLE_BANK_DEPTH);
  localparam int TIDX_W           = 10;
  localparam int BANK_SEL_W       = TIDX_W - BANK_AW;
  localparam int DATA_W           = 16;

  // bank select codes
  localparam logic [BANK_SEL_W-1:0] BANK_0 = BANK_SEL_W'(0);
  localparam logic [BANK_SEL_W-1:0] BANK_1 = BANK_SEL_W'(1);
  localparam logic [BANK_SEL_W-1:0] BANK_2 = BANK_SEL_W'(2);

  // pixel format codes
  localparam logic [2:0] FMT_RGB565_LE = 3'd0;
  localparam logic [2:0] FMT_RGB565_BE = 3'd1;
  localparam logic [2:0] FMT_BGR565_LE = 3'd2;
  localparam logic [2:0] FMT_BGR565_BE = 3'd3;
  localparam logic [2:0] FMT_RGB888    = 3'd4;
  localparam logic [2:0] FMT_BGR888    = 3'd5;
  localparam logic [2:0] FMT_GRAY      = 3'd6;

  // quantization modes
  localparam logic [1:0] QM_NONE  = 2'd0;
  localparam logic [1:0] QM_INT8  = 2'd1;
  localparam logic [1:0] QM_INT16 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SOURCE_FORMAT = 2'd0;
  localparam logic [1:0] CFG_DEST_FORMAT   = 2'd1;
  localparam logic [1:0] CFG_QUANT_MODE    = 2'd2;

  // request types
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TABLE = 1'b1;

  // output value counts
  localparam logic [1:0] CNT_GRAY = 2'd1;
  localparam logic [1:0] CNT_565  = 2'd2;
  localparam logic [1:0] CNT_888  = 2'd3;

  // bt.601 luma weights, scaled by 256
  localparam logic [15:0] GRAY_WR = 16'd77;
  localparam logic [15:0] GRAY_WG = 16'd150;
  localparam logic [15:0] GRAY_WB = 16'd29;

  // table write request
  typedef struct packed {
    logic                         en;
    logic [BANK_SEL_W-1:0]        bank;
    logic [BANK_AW-1:0]           addr;
    logic signed [DATA_W-1:0]     data;
  } tbl_wr_t;

  // table read request, one address per bank
  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr0;
    logic [BANK_AW-1:0] addr1;
    logic [BANK_AW-1:0] addr2;
  } tbl_rd_t;

endpackage

`default_nettype wire

// ----- hdl/pixel_format_converter_quant_core.sv -----
// Pixel format converter with table quantization, one pixel per transfer.
// Input channel (in_valid/in_ready): a pixel to convert, or a write of one
// quantization table entry (in_req_type). Table writes produce no result.
// Result channel (out_valid/out_ready): up to three values, their count and
// the run_end flag of the pixel. Configuration channel (cfg_valid/cfg_ready)
// sets source format, destination format and quant mode; always ready, and
// only to be written while the block holds no pixel.
// Throughput: one transfer per cycle while in_ready is high, pixels and table
// writes alike. The pixel is decoded on entry and looks up three table banks
// in the same cycle; the registered memory read is the first stage, output
// formatting the second; a pixel's result passes both before it is offered.
// A table write lands in memory at its own transfer, so the very next pixel
// already reads the new entry.
// When out_ready is low the output register holds its result and one more
// pixel is taken into the memory stage; after that in_ready drops.
// Reset clears the pipeline and sets rgb565 le in, rgb888 out, no
// quantization; table contents are undefined until written.
`default_nettype none
`include "pixel_format_converter_quant_core_defines.svh"

module pixel_format_converter_quant_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [2:0]                            cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_req_type,
  input  logic [23:0]                           in_pixel_bytes,
  input  logic [pfcq_pkg::TIDX_W-1:0]           in_table_index,
  input  logic signed [pfcq_pkg::DATA_W-1:0]    in_table_value,
  input  logic                                  in_run_end,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pfcq_pkg::DATA_W-1:0]    out_first,
  output logic signed [pfcq_pkg::DATA_W-1:0]    out_second,
  output logic signed [pfcq_pkg::DATA_W-1:0]    out_third,
  output logic [1:0]                            out_count,
  output logic                                  out_run_end_out
);
  import pfcq_pkg::*;

  // configuration registers
  logic [2:0] src_fmt_r;
  logic [2:0] dst_fmt_r;
  logic [1:0] quant_mode_r;

  // handshake
  logic in_accept;
  logic pix_accept;
  logic out_load;

  // entry decode
  logic [7:0]  b0, b1, b2;
  logic [15:0] pix_in;
  logic [7:0]  red, grn, blu;
  logic [15:0] gray_sum;
  logic [7:0]  gray;
  logic [7:0]  ch0, ch2;
  logic [15:0] pix_out;
  logic        dst_565, dst_888, quant_on;
  logic [7:0]  plain0, plain1, plain2;
  logic [1:0]  cnt;

  // memory stage
  logic        s1_valid_r;
  logic [7:0]  s1_plain0_r, s1_plain1_r, s1_plain2_r;
  logic [1:0]  s1_cnt_r;
  logic        s1_run_end_r;
  logic        s1_use_q_r;
  logic        s1_int8_r;
  logic        s1_gray_r;

  tbl_wr_t tbl_wr;
  tbl_rd_t tbl_rd;
  logic signed [DATA_W-1:0] rd_data0, rd_data1, rd_data2;

  // output register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_first_r, out_second_r, out_third_r;
  logic signed [DATA_W-1:0] out_first_nxt, out_second_nxt, out_third_nxt;
  logic [1:0]               out_count_r;
  logic                     out_run_end_r;

  // configuration writes, indexes past the list ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r    <= FMT_RGB565_LE;
      dst_fmt_r    <= FMT_RGB888;
      quant_mode_r <= QM_NONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SOURCE_FORMAT: src_fmt_r    <= cfg_data;
        CFG_DEST_FORMAT:   dst_fmt_r    <= cfg_data;
        CFG_QUANT_MODE:    quant_mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign out_load   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || out_load;
  assign in_accept  = in_valid && in_ready;
  assign pix_accept = in_accept && (in_req_type == REQ_PIXEL);

  // unpack source pixel to 8-bit channels
  always_comb begin
    b0     = in_pixel_bytes[7:0];
    b1     = in_pixel_bytes[15:8];
    b2     = in_pixel_bytes[23:16];
    pix_in = src_fmt_r[0] ? {b0, b1} : {b1, b0};
    if (src_fmt_r <= FMT_BGR565_BE) begin
      grn = {pix_in[10:5], 2'b00};
      if (src_fmt_r[1]) begin
        red = {pix_in[4:0], 3'b000};
        blu = {pix_in[15:11], 3'b000};
      end else begin
        red = {pix_in[15:11], 3'b000};
        blu = {pix_in[4:0], 3'b000};
      end
    end else if (src_fmt_r == FMT_BGR888) begin
      red = b2;
      grn = b1;
      blu = b0;
    end else begin
      red = b0;
      grn = b1;
      blu = b2;
    end
  end

  // luma, sum stays below 2^16
  assign gray_sum = ({8'd0, red} * GRAY_WR) + ({8'd0, grn} * GRAY_WG)
                  + ({8'd0, blu} * GRAY_WB);
  assign gray     = gray_sum[15:8];

  // destination encode
  always_comb begin
    dst_565  = (dst_fmt_r <= FMT_BGR565_BE);
    dst_888  = (dst_fmt_r == FMT_RGB888) || (dst_fmt_r == FMT_BGR888);
    quant_on = (quant_mode_r == QM_INT8) || (quant_mode_r == QM_INT16);
    ch0      = (dst_fmt_r == FMT_BGR888) ? blu : red;
    ch2      = (dst_fmt_r == FMT_BGR888) ? red : blu;
    pix_out  = dst_fmt_r[1] ? {blu[7:3], grn[7:2], red[7:3]}
                            : {red[7:3], grn[7:2], blu[7:3]};
    if (dst_565) begin
      plain0 = dst_fmt_r[0] ? pix_out[15:8] : pix_out[7:0];
      plain1 = dst_fmt_r[0] ? pix_out[7:0] : pix_out[15:8];
      plain2 = 8'd0;
      cnt    = CNT_565;
    end else if (dst_888) begin
      plain0 = ch0;
      plain1 = grn;
      plain2 = ch2;
      cnt    = CNT_888;
    end else begin
      plain0 = gray;
      plain1 = 8'd0;
      plain2 = 8'd0;
      cnt    = CNT_GRAY;
    end
  end

  // table access: writes and lookups both issue at the transfer
  always_comb begin
    tbl_wr.en    = in_accept && (in_req_type == REQ_TABLE);
    tbl_wr.bank  = in_table_index[TIDX_W-1:BANK_AW];
    tbl_wr.addr  = in_table_index[BANK_AW-1:0];
    tbl_wr.data  = in_table_value;
    tbl_rd.en    = pix_accept;
    tbl_rd.addr0 = BANK_AW'(dst_888 ? ch0 : gray);
    tbl_rd.addr1 = BANK_AW'(grn);
    tbl_rd.addr2 = BANK_AW'(ch2);
  end

  pfcq_quant_table u_table (
    .clk      (clk),
    .wr       (tbl_wr),
    .rd       (tbl_rd),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .rd_data2 (rd_data2)
  );

  // memory stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= pix_accept;
    end
  end

  // memory stage payload
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_plain0_r  <= plain0;
      s1_plain1_r  <= plain1;
      s1_plain2_r  <= plain2;
      s1_cnt_r     <= cnt;
      s1_run_end_r <= in_run_end;
      s1_use_q_r   <= quant_on && !dst_565;
      s1_int8_r    <= (quant_mode_r == QM_INT8);
      s1_gray_r    <= !dst_565 && !dst_888;
    end
  end

  // truncation of a table entry to int8 or int16
  function automatic logic signed [DATA_W-1:0] trunc_q(
    input logic signed [DATA_W-1:0] e,
    input logic                     int8
  );
    trunc_q = int8 ? {{(DATA_W-8){e[7]}}, e[7:0]} : e;
  endfunction

  // result select
  always_comb begin
    if (s1_use_q_r) begin
      out_first_nxt  = trunc_q(rd_data0, s1_int8_r);
      out_second_nxt = s1_gray_r ? '0 : trunc_q(rd_data1, s1_int8_r);
      out_third_nxt  = s1_gray_r ? '0 : trunc_q(rd_data2, s1_int8_r);
    end else begin
      out_first_nxt  = {8'd0, s1_plain0_r};
      out_second_nxt = {8'd0, s1_plain1_r};
      out_third_nxt  = {8'd0, s1_plain2_r};
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_first_r   <= out_first_nxt;
      out_second_r  <= out_second_nxt;
      out_third_r   <= out_third_nxt;
      out_count_r   <= s1_cnt_r;
      out_run_end_r <= s1_run_end_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_first       = out_first_r;
  assign out_second      = out_second_r;
  assign out_third       = out_third_r;
  assign out_count       = out_count_r;
  assign out_run_end_out = out_run_end_r;

  // checks
  `PFCQ_ASSERT_NOW(a_third_unused_zero, out_valid && (out_count != CNT_888), out_third == '0, "third value not zero when unused")
  `PFCQ_ASSERT_NOW(a_second_unused_zero, out_valid && (out_count == CNT_GRAY), out_second == '0, "second value not zero for gray")
  `PFCQ_ASSERT_NEXT(a_pixel_enters_stage, pix_accept, s1_valid_r, "accepted pixel missing from memory stage")
  `PFCQ_ASSERT_NEXT(a_stage_holds, s1_valid_r && !out_load, s1_valid_r, "stalled pixel dropped from memory stage")

endmodule

`default_nettype wire

// ----- hdl/pfcq_quant_table.sv -----
`default_nettype none

module pfcq_quant_table (
  input  logic                                  clk,
  input  pfcq_pkg::tbl_wr_t                     wr,
  input  pfcq_pkg::tbl_rd_t                     rd,
  output logic signed [pfcq_pkg::DATA_W-1:0]    rd_data0,
  output logic signed [pfcq_pkg::DATA_W-1:0]    rd_data1,
  output logic signed [pfcq_pkg::DATA_W-1:0]    rd_data2
);
  import pfcq_pkg::*;

  // one memory per channel bank so all three channels look up together
  logic signed [DATA_W-1:0] bank0_mem [TABLE_BANK_DEPTH];
  logic signed [DATA_W-1:0] bank1_mem [TABLE_BANK_DEPTH];
  logic signed [DATA_W-1:0] bank2_mem [TABLE_BANK_DEPTH];

  logic signed [DATA_W-1:0] rd_data0_r;
  logic signed [DATA_W-1:0] rd_data1_r;
  logic signed [DATA_W-1:0] rd_data2_r;

  // write port; an index in the fourth bank matches nothing and is dropped
  always_ff @(posedge clk) begin
    if (wr.en && (wr.bank == BANK_0)) begin
      bank0_mem[wr.addr] <= wr.data;
    end
    if (wr.en && (wr.bank == BANK_1)) begin
      bank1_mem[wr.addr] <= wr.data;
    end
    if (wr.en && (wr.bank == BANK_2)) begin
      bank2_mem[wr.addr] <= wr.data;
    end
  end

  // registered read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data0_r <= bank0_mem[rd.addr0];
      rd_data1_r <= bank1_mem[rd.addr1];
      rd_data2_r <= bank2_mem[rd.addr2];
    end
  end

  assign rd_data0 = rd_data0_r;
  assign rd_data1 = rd_data1_r;
  assign rd_data2 = rd_data2_r;

endmodule

`default_nettype wire
